// ===== hw/rtl/btbl_pkg.sv =====
// Shared types, codes and helpers for the box table bisection lookup unit.
package btbl_pkg;

  localparam int COUNT_W = 5;
  localparam int CAP_W   = 3;
  localparam int COMP_W  = 32;

  localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = 5'd1;

  // Register select bit of the configuration port (byte address bit 2).
  localparam logic REG_ENTRY_COUNT = 1'b0;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_NO_BOX  = 2'd2;

  // Box test outcome: inside, first violation on a lower or an upper bound.
  localparam logic [1:0] TEST_INSIDE = 2'd0;
  localparam logic [1:0] TEST_LOW    = 2'd1;
  localparam logic [1:0] TEST_HIGH   = 2'd2;

  typedef struct packed {
    logic               func;
    logic [3:0]         entry;
    logic [1:0]         comp;
    logic signed [31:0] lower_value;
    logic signed [31:0] upper_value;
    logic signed [31:0] point_0;
    logic signed [31:0] point_1;
    logic signed [31:0] point_2;
    logic signed [31:0] point_3;
  } item_t;

  typedef struct packed {
    logic [3:0] box_index;
    logic [1:0] status;
  } result_t;

  // Bisection step cap (most box checks before the final recheck): ceil(log2(n)) + 1.
  function automatic logic [CAP_W-1:0] search_cap(logic [COUNT_W-1:0] n);
    logic [CAP_W-1:0] c;
    c = 3'd1;
    for (int k = 0; k < COUNT_W; k++) begin
      if ((6'd1 << (c - 3'd1)) < {1'b0, n}) begin
        c = c + 3'd1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/btbl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module btbl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/btbl_box_test.sv =====
// Point against box test: first violated component decides the outcome.
module btbl_box_test #(
  parameter int DIMS = 4
) (
  input  logic [DIMS*32-1:0] point_row,
  input  logic [DIMS*32-1:0] lower_row,
  input  logic [DIMS*32-1:0] upper_row,
  output logic [1:0]         code
);
  import btbl_pkg::*;

  // Walk from the top component down so the lowest violation wins.
  always_comb begin
    code = TEST_INSIDE;
    for (int d = DIMS - 1; d >= 0; d--) begin
      if ($signed(point_row[d*COMP_W +: COMP_W]) < $signed(lower_row[d*COMP_W +: COMP_W])) begin
        code = TEST_LOW;
      end else if ($signed(point_row[d*COMP_W +: COMP_W]) >
                   $signed(upper_row[d*COMP_W +: COMP_W])) begin
        code = TEST_HIGH;
      end
    end
  end

endmodule

// ===== hw/rtl/btbl_ctrl.sv =====
// Sequencer: box loads by read-modify-write, queries by family check and bisection.
module btbl_ctrl #(
  parameter int MAX_BOXES = 16,
  parameter int DIMS      = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [btbl_pkg::COUNT_W-1:0] entry_count,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  btbl_pkg::item_t           item,
  output logic                      res_valid,
  input  logic                      res_ready,
  output btbl_pkg::result_t         res
);
  import btbl_pkg::*;

  localparam int AW    = MAX_BOXES > 1 ? $clog2(MAX_BOXES) : 1;
  localparam int ROW_W = DIMS * COMP_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LDWR = 3'd1;
  localparam logic [2:0] S_FAM  = 3'd2;
  localparam logic [2:0] S_SCHK = 3'd3;
  localparam logic [2:0] S_FCHK = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]         state;
  item_t              cur;
  logic [COUNT_W-1:0] n;
  logic [CAP_W-1:0]   cap;
  logic [CAP_W-1:0]   steps;
  logic [COUNT_W-1:0] lo;
  logic [COUNT_W-1:0] up;
  logic [COUNT_W-1:0] idx;

  logic [COUNT_W-1:0] n_in;
  logic [COUNT_W-1:0] lo_sel;
  logic [COUNT_W-1:0] up_sel;
  logic [COUNT_W-1:0] mid;
  logic [COUNT_W-1:0] mid_clamp;
  logic               last;
  logic [COUNT_W-1:0] rd_lo_box;
  logic [COUNT_W-1:0] rd_up_box;
  logic               ram_we;
  logic               load_ok;
  logic [ROW_W-1:0]   lo_rdata;
  logic [ROW_W-1:0]   up_rdata;
  logic [ROW_W-1:0]   lo_wdata;
  logic [ROW_W-1:0]   up_wdata;
  logic [ROW_W-1:0]   point_row;
  logic [1:0]         code;
  logic signed [31:0] pts [4];

  assign pts[0] = cur.point_0;
  assign pts[1] = cur.point_1;
  assign pts[2] = cur.point_2;
  assign pts[3] = cur.point_3;

  // Components beyond the fourth have no point field and read as zero.
  for (genvar d = 0; d < DIMS; d++) begin : g_point
    if (d < 4) begin : g_have
      assign point_row[d*COMP_W +: COMP_W] = pts[d];
    end else begin : g_zero
      assign point_row[d*COMP_W +: COMP_W] = '0;
    end
  end

  btbl_ram #(.WIDTH(ROW_W), .DEPTH(MAX_BOXES)) u_lower (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(cur.entry)),
    .wdata (lo_wdata),
    .raddr (AW'(rd_lo_box)),
    .rdata (lo_rdata)
  );

  btbl_ram #(.WIDTH(ROW_W), .DEPTH(MAX_BOXES)) u_upper (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(cur.entry)),
    .wdata (up_wdata),
    .raddr (AW'(rd_up_box)),
    .rdata (up_rdata)
  );

  btbl_box_test #(.DIMS(DIMS)) u_test (
    .point_row (point_row),
    .lower_row (lo_rdata),
    .upper_row (up_rdata),
    .code      (code)
  );

  assign item_ready = (state == S_IDLE);
  assign res_valid  = (state == S_EMIT);
  assign load_ok    = (int'(cur.entry) < MAX_BOXES) && (int'(cur.comp) < DIMS);
  assign ram_we     = (state == S_LDWR) && load_ok;

  // Merge the loaded component into the row read back from the table.
  always_comb begin
    lo_wdata = lo_rdata;
    up_wdata = up_rdata;
    for (int d = 0; d < DIMS; d++) begin
      if (d == int'(cur.comp)) begin
        lo_wdata[d*COMP_W +: COMP_W] = cur.lower_value;
        up_wdata[d*COMP_W +: COMP_W] = cur.upper_value;
      end
    end
  end

  always_comb begin
    if (entry_count == '0) begin
      n_in = COUNT_W'(1);
    end else if (int'(entry_count) > MAX_BOXES) begin
      n_in = COUNT_W'(MAX_BOXES);
    end else begin
      n_in = entry_count;
    end

    lo_sel    = (code == TEST_LOW) ? lo  : idx;
    up_sel    = (code == TEST_LOW) ? idx : up;
    mid       = COUNT_W'(({1'b0, lo_sel} + {1'b0, up_sel}) >> 1);
    mid_clamp = (mid >= n) ? n - COUNT_W'(1) : mid;
    last      = (steps + CAP_W'(1)) == cap;

    rd_lo_box = idx;
    rd_up_box = idx;
    case (state)
      S_IDLE: begin
        if (item.func == FUNC_QUERY) begin
          rd_lo_box = '0;
          rd_up_box = n_in - COUNT_W'(1);
        end else begin
          rd_lo_box = COUNT_W'(item.entry);
          rd_up_box = COUNT_W'(item.entry);
        end
      end
      S_FAM: begin
        rd_lo_box = n >> 1;
        rd_up_box = n >> 1;
      end
      S_SCHK: begin
        rd_lo_box = last ? mid_clamp : mid;
        rd_up_box = last ? mid_clamp : mid;
      end
      default: begin
        rd_lo_box = idx;
        rd_up_box = idx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur   <= item;
            n     <= n_in;
            cap   <= search_cap(n_in);
            state <= (item.func == FUNC_QUERY) ? S_FAM : S_LDWR;
          end
        end
        S_LDWR: begin
          state <= S_IDLE;
        end
        S_FAM: begin
          if (code != TEST_INSIDE) begin
            res   <= '{box_index: 4'd0, status: ST_OUTSIDE};
            state <= S_EMIT;
          end else begin
            idx   <= n >> 1;
            lo    <= '0;
            up    <= n;
            steps <= '0;
            state <= S_SCHK;
          end
        end
        S_SCHK: begin
          if (code == TEST_INSIDE) begin
            res   <= '{box_index: idx[3:0], status: ST_FOUND};
            state <= S_EMIT;
          end else begin
            lo    <= lo_sel;
            up    <= up_sel;
            steps <= steps + CAP_W'(1);
            idx   <= last ? mid_clamp : mid;
            state <= last ? S_FCHK : S_SCHK;
          end
        end
        S_FCHK: begin
          if (code == TEST_INSIDE) begin
            res <= '{box_index: idx[3:0], status: ST_FOUND};
          end else begin
            res <= '{box_index: 4'd0, status: ST_NO_BOX};
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_steps_capped: assert property (@(posedge clk) disable iff (rst)
    state == S_SCHK |-> steps < cap)
    else $error("bisection ran past its step cap");

  a_idx_in_use: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCHK || state == S_FCHK) |-> idx < n)
    else $error("bisection index left the used boxes");

  a_write_only_load: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_LDWR && cur.func == FUNC_LOAD))
    else $error("table written outside a load");

  a_query_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> cur.func == FUNC_QUERY)
    else $error("result raised for a load");

endmodule

// ===== hw/rtl/box_table_bisection_lookup_unit.sv =====
// Top level: configuration port, lookup sequencer and result output register.
//
//  channel   dir  handshake                     payload
//  item      in   item_valid / item_ready       item   (btbl_pkg::item_t)
//  result    out  result_valid / result_ready   result (btbl_pkg::result_t)
//  config    in   APB psel/penable/pwrite       entry_count at byte address 0
//
//  A load reads the box row, then writes it back with one component merged.
//  A query runs a family check and, if the point passes it, up to ceil(log2(n)) + 1
//  bisection box reads, a final recheck when the cap ends the search, and the hand-over
//  of the beat; the two table RAM read ports set the pace.
//  Reset (rst, synchronous) idles the sequencer, drops the result beat and sets
//  entry_count to 1; the table keeps its contents and needs no clearing pass.
//  A stalled result beat holds in the output register; the sequencer waits for it
//  to drain, and a new item is taken as soon as the sequencer is idle.
module box_table_bisection_lookup_unit #(
  parameter int MAX_BOXES = 16,
  parameter int DIMS      = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                item_valid,
  output logic                item_ready,
  input  btbl_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_ready,
  output btbl_pkg::result_t   result
);
  import btbl_pkg::*;

  logic [COUNT_W-1:0] entry_count;
  logic               cfg_write;
  logic               res_valid;
  logic               res_ready;
  result_t            res;

  // Configuration: one register, no wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= ENTRY_COUNT_RESET;
    end else if (cfg_write && paddr[2] == REG_ENTRY_COUNT) begin
      entry_count <= pwdata[COUNT_W-1:0];
    end
  end

  // Reads of anything past register 0 return zero.
  assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? {{(32-COUNT_W){1'b0}}, entry_count} : '0;

  btbl_ctrl #(.MAX_BOXES(MAX_BOXES), .DIMS(DIMS)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .entry_count (entry_count),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // Output register: take a new beat when empty or when the current one drains.
  assign res_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      result <= res;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("pending result beat overwritten");

  a_count_write: assert property (@(posedge clk) disable iff (rst)
    cfg_write && paddr[2] == REG_ENTRY_COUNT |=> entry_count == $past(pwdata[COUNT_W-1:0]))
    else $error("entry_count write lost");

  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !item_ready)
    else $error("item taken while a result is pending in the sequencer");

endmodule
